// ===== hw/rtl/rte_pkg.sv =====
// rte_pkg: shared constants and types of the rtt estimator
// register indexes, reset values and the controller-to-datapath command group
// no dependencies
package rte_pkg;

  // default time width, Q(T-16).16 seconds
  localparam int TIME_WIDTH_DEF = 32;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_WEIGHT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION_WEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_GRAIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_GAIN        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_GAIN        = 3'd5;

  // configuration data width, widest register
  localparam int CFG_DATA_W = 17;

  // configuration reset values
  localparam logic [16:0] SMOOTH_GAIN_RST      = 17'd32768;
  localparam logic [15:0] MEAN_WEIGHT_RST      = 16'd307;
  localparam logic [15:0] DEVIATION_WEIGHT_RST = 16'd1024;
  localparam logic [16:0] FAST_GAIN_RST        = 17'd58982;
  localparam logic [16:0] SLOW_GAIN_RST        = 17'd655;

  // unity gain in Q1.16
  localparam logic [16:0] GAIN_ONE = 17'h10000;

  // reset value of the rtt averages, 2 seconds in Q16.16
  localparam logic [31:0] RESET_TIME = 32'd131072;

  // commands from the sequencer, one step of the update each
  typedef struct packed {
    logic load;     // take the sample, seed averages on the first one
    logic mul_dev;  // multiply srtt/deviation blends
    logic mul_avg;  // fold srtt/deviation products, multiply fast/slow blends
    logic mul_tmo;  // fold fast/slow products, multiply timeout terms
    logic finish;   // form the timeout and write the result register
  } rte_cmd_t;

endpackage

// ===== hw/rtl/rte_ctrl.sv =====
// rte_ctrl: sequencer of the rtt estimator
// steps the datapath through its multiply phases and owns the stream handshakes
// depends on rte_pkg
module rte_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output rte_pkg::rte_cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    MUL_A,
    MUL_B,
    MUL_C,
    FINISH
  } state_t;

  state_t state;
  logic   out_valid;
  logic   can_write;

  // result register is free when empty or being drained this cycle
  assign can_write     = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == IDLE);
  assign m_axis_tvalid = out_valid;

  // commands decoded from the state
  always_comb begin
    cmd         = '0;
    cmd.load    = (state == IDLE) && s_axis_tvalid;
    cmd.mul_dev = (state == MUL_A);
    cmd.mul_avg = (state == MUL_B);
    cmd.mul_tmo = (state == MUL_C);
    cmd.finish  = (state == FINISH) && can_write;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // set on a new result, cleared once the receiver takes it
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            state <= MUL_A;
          end
        end
        MUL_A:  state <= MUL_B;
        MUL_B:  state <= MUL_C;
        MUL_C:  state <= FINISH;
        FINISH: begin
          if (can_write) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rte_dp.sv =====
// rte_dp: datapath of the rtt estimator
// configuration registers, averages, two shared multiplier lanes, result register
// depends on rte_pkg
module rte_dp #(
  parameter int TIME_WIDTH = rte_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rte_pkg::rte_cmd_t              cmd,
  input  logic [TIME_WIDTH-1:0]          sample_in,
  input  logic                           cfg_write,
  input  logic [rte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rte_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [TIME_WIDTH-1:0]          smoothed_rtt,
  output logic [TIME_WIDTH-1:0]          rtt_deviation,
  output logic [TIME_WIDTH-1:0]          retrans_timeout,
  output logic [TIME_WIDTH-1:0]          fast_rtt,
  output logic [TIME_WIDTH-1:0]          slow_rtt
);

  localparam int TW = TIME_WIDTH;
  localparam int PW = TW + 19;   // signed (TW+1) x signed 18 product
  localparam int QW = PW - 8;    // timeout before clamping
  localparam logic [TW+19:0] HALF_Q16 = (TW+20)'(32768);

  // configuration
  logic [16:0] smooth_gain;
  logic [15:0] mean_weight;
  logic [15:0] deviation_weight;
  logic        fine_grain_enable;
  logic [16:0] fast_gain;
  logic [16:0] slow_gain;

  // estimator state
  logic [TW-1:0] sample;
  logic [TW-1:0] srtt;
  logic [TW-1:0] dev;
  logic [TW-1:0] fast_avg;
  logic [TW-1:0] slow_avg;
  logic          first_pending;

  // multiplier lanes
  logic signed [TW:0]   opa0, opa1;
  logic        [16:0]   opk0, opk1;
  logic signed [PW-1:0] prod0, prod1;

  logic [TW-1:0] absdiff;
  logic [PW-1:0] tsum;
  logic [QW-1:0] tq;
  logic [TW-1:0] timeout;

  function automatic logic [16:0] clamp_gain(input logic [16:0] k);
    return k[16] ? rte_pkg::GAIN_ONE : k;
  endfunction

  function automatic logic signed [TW:0] diff(input logic [TW-1:0] b,
                                              input logic [TW-1:0] a);
    return $signed({1'b0, b}) - $signed({1'b0, a});
  endfunction

  // a + (b - a) * k, rounded half up; p holds (b - a) * k
  function automatic logic [TW-1:0] blend(input logic [TW-1:0] a,
                                          input logic [PW-1:0] p);
    logic [TW+19:0] acc;
    acc = {4'b0, a, 16'b0} + {p[PW-1], p} + HALF_Q16;
    return acc[TW+15:16];
  endfunction

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_gain       <= rte_pkg::SMOOTH_GAIN_RST;
      mean_weight       <= rte_pkg::MEAN_WEIGHT_RST;
      deviation_weight  <= rte_pkg::DEVIATION_WEIGHT_RST;
      fine_grain_enable <= 1'b0;
      fast_gain         <= rte_pkg::FAST_GAIN_RST;
      slow_gain         <= rte_pkg::SLOW_GAIN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        rte_pkg::CFG_SMOOTH_GAIN:      smooth_gain       <= cfg_data;
        rte_pkg::CFG_MEAN_WEIGHT:      mean_weight       <= cfg_data[15:0];
        rte_pkg::CFG_DEVIATION_WEIGHT: deviation_weight  <= cfg_data[15:0];
        rte_pkg::CFG_FINE_GRAIN:       fine_grain_enable <= cfg_data[0];
        rte_pkg::CFG_FAST_GAIN:        fast_gain         <= cfg_data;
        rte_pkg::CFG_SLOW_GAIN:        slow_gain         <= cfg_data;
        default: ;
      endcase
    end
  end

  assign absdiff = (sample >= srtt) ? (sample - srtt) : (srtt - sample);

  // operand select per phase
  always_comb begin
    if (cmd.mul_avg) begin
      opa0 = diff(sample, fast_avg);
      opk0 = clamp_gain(fast_gain);
      opa1 = diff(sample, slow_avg);
      opk1 = clamp_gain(slow_gain);
    end else if (cmd.mul_tmo) begin
      opa0 = $signed({1'b0, srtt});
      opk0 = {1'b0, mean_weight};
      opa1 = $signed({1'b0, dev});
      opk1 = {1'b0, deviation_weight};
    end else begin
      opa0 = diff(sample, srtt);
      opk0 = clamp_gain(smooth_gain);
      opa1 = diff(absdiff, dev);
      opk1 = clamp_gain(smooth_gain);
    end
  end

  // registered products, held while the result waits
  always_ff @(posedge clk) begin
    if (cmd.mul_dev || cmd.mul_avg || cmd.mul_tmo) begin
      prod0 <= PW'(opa0) * PW'($signed({1'b0, opk0}));
      prod1 <= PW'(opa1) * PW'($signed({1'b0, opk1}));
    end
  end

  // timeout: round half up of the Q.24 sum, then saturate
  assign tsum    = prod0 + prod1;
  assign tq      = tsum[PW-1:8] + QW'(tsum[7]);
  assign timeout = (tq[QW-1:TW] != '0) ? '1 : tq[TW-1:0];

  // averages and first-sample seeding
  always_ff @(posedge clk) begin
    if (rst) begin
      srtt          <= TW'(rte_pkg::RESET_TIME);
      dev           <= '0;
      fast_avg      <= TW'(rte_pkg::RESET_TIME);
      slow_avg      <= TW'(rte_pkg::RESET_TIME);
      first_pending <= 1'b1;
    end else begin
      if (cmd.load && first_pending) begin
        srtt          <= sample_in;
        dev           <= '0;
        fast_avg      <= sample_in;
        slow_avg      <= sample_in;
        first_pending <= 1'b0;
      end
      if (cmd.mul_avg) begin
        srtt <= blend(srtt, prod0);
        dev  <= blend(dev, prod1);
      end
      if (cmd.mul_tmo && fine_grain_enable) begin
        fast_avg <= blend(fast_avg, prod0);
        slow_avg <= blend(slow_avg, prod1);
      end
    end
  end

  // sample and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample <= sample_in;
    end
    if (cmd.finish) begin
      smoothed_rtt    <= srtt;
      rtt_deviation   <= dev;
      retrans_timeout <= timeout;
      fast_rtt        <= fast_avg;
      slow_rtt        <= slow_avg;
    end
  end

endmodule

// ===== hw/rtl/rtt_estimator_timeout.sv =====
// rtt_estimator_timeout: top level of the rtt estimator with timeout
// joins the sequencer rte_ctrl and the datapath rte_dp
// depends on rte_pkg, rte_ctrl, rte_dp
//
// Usage: each item on the s_axis channel is one round-trip-time sample in
// Q16.16 seconds. For each sample the block returns one item on m_axis with
// the updated smoothed rtt, mean deviation, retransmission timeout
// (mean_weight*srtt + deviation_weight*dev, saturating) and the fast and slow
// rtt averages. The cfg channel writes the six configuration registers by index;
// it is always ready and should be used while no sample is in flight.
// Samples are taken one at a time, stepping through MUL_A, MUL_B, MUL_C and
// FINISH, which writes the result; a new sample is accepted at the earliest the
// cycle after the result is written. The four steps come
// from the dependent multiply passes through the two shared multiplier lanes.
// Reset sets the registers to their defaults, the averages to 2 s and arms
// first-sample seeding. If the receiver stalls, the finished result waits in
// the output register while the next sample is taken and processed; the
// block then holds in its last step until the register frees up.
module rtt_estimator_timeout #(
  parameter int TIME_WIDTH = rte_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // rtt_sample
  input  logic [((TIME_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // smoothed_rtt, rtt_deviation, retrans_timeout, fast_rtt, slow_rtt
  output logic [((5*TIME_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rte_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int OUT_W = ((5 * TIME_WIDTH + 7) / 8) * 8;

  rte_pkg::rte_cmd_t     cmd;
  logic [TIME_WIDTH-1:0] smoothed_rtt;
  logic [TIME_WIDTH-1:0] rtt_deviation;
  logic [TIME_WIDTH-1:0] retrans_timeout;
  logic [TIME_WIDTH-1:0] fast_rtt;
  logic [TIME_WIDTH-1:0] slow_rtt;

  assign cfg_ready = 1'b1;

  rte_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd)
  );

  rte_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sample_in       (s_axis_tdata[TIME_WIDTH-1:0]),
    .cfg_write       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .smoothed_rtt    (smoothed_rtt),
    .rtt_deviation   (rtt_deviation),
    .retrans_timeout (retrans_timeout),
    .fast_rtt        (fast_rtt),
    .slow_rtt        (slow_rtt)
  );

  // pack result fields, first field lowest, zero fill to bytes
  assign m_axis_tdata = OUT_W'({slow_rtt, fast_rtt, retrans_timeout,
                                rtt_deviation, smoothed_rtt});

endmodule

// ===== tb/sv/rtt_estimator_timeout_test.sv =====
// rtt_estimator_timeout_test: self-checking testbench of the rtt estimator
// predicts srtt, deviation, timeout and fast/slow averages for every sample
// depends on rte_pkg and rtt_estimator_timeout
module rtt_estimator_timeout_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW = 32;
  localparam int OUT_W = ((5 * TW + 7) / 8) * 8;
  // register indexes that the block does not decode
  localparam logic [rte_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [rte_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 95;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  // one result item, lowest field in the lowest bits
  typedef struct packed {
    logic [31:0] slow_rtt;
    logic [31:0] fast_rtt;
    logic [31:0] retrans_timeout;
    logic [31:0] rtt_deviation;
    logic [31:0] smoothed_rtt;
  } rtt_estimate_t;

  // tracks estimator state and the estimates still due from the block
  class rtt_tracker;
    logic [16:0] smooth_gain;
    logic [15:0] mean_weight;
    logic [15:0] dev_weight;
    logic        fine_grain;
    logic [16:0] fast_gain;
    logic [16:0] slow_gain;
    logic [31:0] srtt;
    logic [31:0] dev;
    logic [31:0] fast_avg;
    logic [31:0] slow_avg;
    logic        seed_pending;
    rtt_estimate_t due[$];
    int unsigned faults;

    function new();
      smooth_gain = rte_pkg::SMOOTH_GAIN_RST;
      mean_weight = rte_pkg::MEAN_WEIGHT_RST;
      dev_weight = rte_pkg::DEVIATION_WEIGHT_RST;
      fine_grain = 1'b0;
      fast_gain = rte_pkg::FAST_GAIN_RST;
      slow_gain = rte_pkg::SLOW_GAIN_RST;
      srtt = rte_pkg::RESET_TIME;
      dev = '0;
      fast_avg = rte_pkg::RESET_TIME;
      slow_avg = rte_pkg::RESET_TIME;
      seed_pending = 1'b1;
      faults = 0;
    endfunction

    function void set_register(logic [rte_pkg::CFG_IDX_W-1:0] idx, logic [16:0] val);
      case (idx)
        rte_pkg::CFG_SMOOTH_GAIN:      smooth_gain = val;
        rte_pkg::CFG_MEAN_WEIGHT:      mean_weight = val[15:0];
        rte_pkg::CFG_DEVIATION_WEIGHT: dev_weight = val[15:0];
        rte_pkg::CFG_FINE_GRAIN:       fine_grain = val[0];
        rte_pkg::CFG_FAST_GAIN:        fast_gain = val;
        rte_pkg::CFG_SLOW_GAIN:        slow_gain = val;
        default: ;
      endcase
    endfunction

    // move a toward b by gain k, gains above one act as one, round half up
    function logic [31:0] blend_toward(logic [31:0] a, logic [31:0] b, logic [16:0] k);
      logic [63:0] g;
      logic [63:0] a64;
      logic [63:0] b64;
      logic [63:0] one;
      logic [63:0] acc;
      one = {47'd0, rte_pkg::GAIN_ONE};
      g = (k > rte_pkg::GAIN_ONE) ? one : {47'd0, k};
      a64 = {32'd0, a};
      b64 = {32'd0, b};
      acc = a64 * (one - g) + b64 * g + 64'd32768;
      return acc[47:16];
    endfunction

    // mu*srtt + phi*dev in Q.24, rounded to Q.16 and saturated
    function logic [31:0] form_timeout(logic [31:0] s_rtt, logic [31:0] d);
      logic [63:0] s;
      logic [63:0] q;
      s = {48'd0, mean_weight} * {32'd0, s_rtt} + {48'd0, dev_weight} * {32'd0, d};
      q = (s >> 8) + ((s >> 7) & 64'd1);
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // accepted sample: advance the state and queue the estimate it yields
    function void take_sample(logic [31:0] sample);
      logic [31:0] old_srtt;
      logic [31:0] diff;
      rtt_estimate_t est;
      if (seed_pending) begin
        srtt = sample;
        fast_avg = sample;
        slow_avg = sample;
        dev = '0;
        seed_pending = 1'b0;
      end
      old_srtt = srtt;
      diff = (sample >= old_srtt) ? sample - old_srtt : old_srtt - sample;
      srtt = blend_toward(old_srtt, sample, smooth_gain);
      dev = blend_toward(dev, diff, smooth_gain);
      if (fine_grain) begin
        fast_avg = blend_toward(fast_avg, sample, fast_gain);
        slow_avg = blend_toward(slow_avg, sample, slow_gain);
      end
      est.smoothed_rtt = srtt;
      est.rtt_deviation = dev;
      est.retrans_timeout = form_timeout(srtt, dev);
      est.fast_rtt = fast_avg;
      est.slow_rtt = slow_avg;
      due.push_back(est);
    endfunction

    // accepted result: compare with the oldest estimate due
    function void compare_estimate(logic [OUT_W-1:0] data);
      rtt_estimate_t got;
      rtt_estimate_t want;
      bit bad;
      got = data[5*TW-1:0];
      if (due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: result with nothing expected: %h", $time, data);
        return;
      end
      want = due.pop_front();
      bad = (got.smoothed_rtt !== want.smoothed_rtt)
          | (got.rtt_deviation !== want.rtt_deviation)
          | (got.retrans_timeout !== want.retrans_timeout)
          | (got.fast_rtt !== want.fast_rtt)
          | (got.slow_rtt !== want.slow_rtt);
      if (bad) begin
        faults++;
        if (faults <= 10)
          $display("%0t: mismatch srtt %h/%h dev %h/%h rto %h/%h fast %h/%h slow %h/%h",
                   $time, want.smoothed_rtt, got.smoothed_rtt,
                   want.rtt_deviation, got.rtt_deviation,
                   want.retrans_timeout, got.retrans_timeout,
                   want.fast_rtt, got.fast_rtt, want.slow_rtt, got.slow_rtt);
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [rte_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rte_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  rtt_tracker tracker = new();

  int       burst_left = 0;
  int       hold_left = 0;
  bit       hold_go = 1'b0;
  int       seg_left = 0;
  int       sparse_tick = 0;
  rx_mode_t rx_mode = RX_OPEN;

  rtt_estimator_timeout #(
    .TIME_WIDTH(TW)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stall segments, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        seg_left = $urandom_range(1, 60);
      end
      seg_left--;
      sparse_tick++;
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: m_axis_tready <= ((sparse_tick % 4) == 0);
        default:   m_axis_tready <= ($urandom_range(0, 99) < 85);
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      tracker.compare_estimate(m_axis_tdata);
  end

  // offer one sample, in bursts with random gaps, and wait for acceptance
  task automatic send_sample(input logic [31:0] sample);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= sample;
    do @(posedge clk); while (!s_axis_tready);
    tracker.take_sample(sample);
  endtask

  // stop offering and wait until every estimate has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [rte_pkg::CFG_IDX_W-1:0] idx,
                                input logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, val);
  endtask

  // idle the block, then write every register and one undecoded index
  task automatic set_all(input logic [16:0] sg, input logic [16:0] mw,
                         input logic [16:0] dw, input logic [16:0] fg,
                         input logic [16:0] fa, input logic [16:0] sl);
    logic [31:0] r;
    drain();
    r = $urandom;
    write_register(r[17] ? CFG_SPARE_HI : CFG_SPARE_LO, r[16:0]);
    write_register(rte_pkg::CFG_SMOOTH_GAIN, sg);
    write_register(rte_pkg::CFG_MEAN_WEIGHT, mw);
    write_register(rte_pkg::CFG_DEVIATION_WEIGHT, dw);
    write_register(rte_pkg::CFG_FINE_GRAIN, fg);
    write_register(rte_pkg::CFG_FAST_GAIN, fa);
    write_register(rte_pkg::CFG_SLOW_GAIN, sl);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [16:0] pick_gain();
    logic [31:0] r;
    case ($urandom_range(0, 7))
      0:       r = 0;
      1:       r = {15'd0, rte_pkg::GAIN_ONE};
      2:       r = $urandom_range(65537, 131071);
      3:       r = {15'd0, rte_pkg::SMOOTH_GAIN_RST};
      default: r = $urandom_range(0, 65536);
    endcase
    return r[16:0];
  endfunction

  function automatic logic [16:0] pick_weight();
    logic [31:0] r;
    case ($urandom_range(0, 7))
      0:       r = 0;
      1:       r = 32'h0000_FFFF;
      2:       r = 256;
      3:       r = $urandom;
      default: r = $urandom_range(0, 2047);
    endcase
    return r[16:0];
  endfunction

  function automatic logic [31:0] pick_sample();
    logic [31:0] r;
    case ($urandom_range(0, 9))
      0:       r = '0;
      1:       r = '1;
      2, 3:    r = $urandom;
      4, 5:    r = tracker.srtt + $urandom_range(0, 4000) - 2000;
      6:       r = $urandom_range(0, 65535);
      7:       r = 32'd1 << $urandom_range(0, 31);
      8:       r = ~(32'd1 << $urandom_range(0, 31));
      default: r = $urandom_range(3000, 200000);
    endcase
    return r;
  endfunction

  // main sequence
  initial begin
    logic [31:0] r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: first sample seeds the averages, then extremes
    send_sample(32'h0000_0CCD);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(rte_pkg::RESET_TIME);

    // unity smoothing, largest weights: timeout saturates
    set_all(rte_pkg::GAIN_ONE, 17'h0FFFF, 17'h0FFFF, 17'd1, 17'd0, rte_pkg::GAIN_ONE);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h1234_5678);

    // gains above one, zero weights
    set_all(17'h1FFFF, 17'd0, 17'd0, 17'd1, 17'h1FFFF, 17'h10001);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h8000_0000);

    // zero smoothing, fine grain off so fast/slow hold their values
    set_all(17'd0, 17'd256, 17'h1FFFF, 17'h1FFFE, rte_pkg::GAIN_ONE, 17'd0);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'h5555_5555);
    send_sample(32'hAAAA_AAAA);

    // smallest nonzero settings
    set_all(17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1);
    send_sample(32'h0000_0001);
    send_sample(32'hFFFF_FFFE);

    // random phases, each with its own settings
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      r = $urandom;
      set_all(pick_gain(), pick_weight(), pick_weight(), r[16:0], pick_gain(), pick_gain());
      if (phase == 2 || phase == 7)
        hold_go = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_sample(pick_sample());
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.faults == 0 && tracker.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
